// ----- hw/rtl/cbm_pkg.sv -----
package cbm_pkg;

  typedef enum logic [1:0] {
    OP_RESET_LOAD = 2'd0,
    OP_REG_WRITE  = 2'd1,
    OP_PRG_XLATE  = 2'd2,
    OP_CHR_XLATE  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT = 2'd1;

  localparam logic [15:0] ADDR_CHR_PAIR_LO  = 16'h7EF0;
  localparam logic [15:0] ADDR_CHR_PAIR_HI  = 16'h7EF1;
  localparam logic [15:0] ADDR_CHR_SINGLE_0 = 16'h7EF2;
  localparam logic [15:0] ADDR_CHR_SINGLE_3 = 16'h7EF5;
  localparam logic [15:0] ADDR_CONTROL      = 16'h7EF6;
  localparam logic [15:0] ADDR_PRG_0        = 16'h7EFA;
  localparam logic [15:0] ADDR_PRG_2        = 16'h7EFC;

  localparam logic [7:0] PAIR_MASK  = 8'hFE;
  localparam int         SWAP_BIT   = 1;
  localparam int         MIRROR_BIT = 0;

  localparam logic [8:0] PRG_COUNT_RST = 9'd16;
  localparam logic [8:0] CHR_COUNT_RST = 9'd128;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bank;
    logic       mirroring_vertical;
  } out_item_t;

endpackage

// ----- hw/rtl/cartridge_bank_mapper_x1_017_core.sv -----
// Bank mapper core for an X1-017 style cartridge.
// Input channel (in_valid/in_ready/in_item): one request per item, carrying a
// reset-load, a register write, a program translate or a pattern translate.
// Result channel (out_valid/out_ready/out_item): exactly one result per
// request, in order: the slot bank number for translates (zero otherwise) and
// the mirroring after the request.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): program and pattern
// bank counts, always ready; write only while no request is in flight.
// Path: a request enters the input register, then slot update and result register
// act on it in one stage.
// Throughput: one request per cycle while out_ready holds; slot state is read and
// written in the same stage, so back-to-back requests see each other's updates.
// Receiver stall: the result register holds, the input register fills, then
// in_ready drops until out_ready returns. No result is dropped.
// Reset: slots come up as after a reset-load with counts 16 and 128
// (program 0,1,14,15, pattern 0..7, swap off, mirroring vertical).
module cartridge_bank_mapper_x1_017_core
  import cbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [8:0] prg_count_r;
  logic [8:0] chr_count_r;

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r, out_item_nxt;

  logic [7:0] prg_slot_r [4];
  logic [7:0] prg_slot_nxt [4];
  logic [7:0] chr_slot_r [8];
  logic [7:0] chr_slot_nxt [8];
  logic       swap_r, swap_nxt;
  logic       mirror_r, mirror_nxt;

  logic       adv;
  logic       fire;
  logic [1:0] low_off;
  logic [7:0] pair;
  logic [8:0] prg_m1, prg_m2;

  assign adv       = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && adv;
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // 0x7EF2..5 and 0x7EFA..C both map to slot offset addr[1:0] - 2
  assign low_off = s1_item_r.address[1:0] - 2'd2;
  assign pair    = s1_item_r.data & PAIR_MASK;
  assign prg_m1  = prg_count_r - 9'd1;
  assign prg_m2  = prg_count_r - 9'd2;

  always_comb begin
    prg_slot_nxt = prg_slot_r;
    chr_slot_nxt = chr_slot_r;
    swap_nxt     = swap_r;
    mirror_nxt   = mirror_r;
    out_item_nxt.bank = 8'd0;

    unique case (op_t'(s1_item_r.operation))
      OP_RESET_LOAD: begin
        prg_slot_nxt[0] = 8'd0;
        prg_slot_nxt[1] = 8'd1;
        prg_slot_nxt[2] = prg_m2[7:0];
        prg_slot_nxt[3] = prg_m1[7:0];
        if (chr_count_r != 9'd0) begin
          for (int i = 0; i < 8; i++) begin
            chr_slot_nxt[i] = 8'(i);
          end
        end
        swap_nxt   = 1'b0;
        mirror_nxt = 1'b1;
      end
      OP_REG_WRITE: begin
        if (s1_item_r.address == ADDR_CHR_PAIR_LO ||
            s1_item_r.address == ADDR_CHR_PAIR_HI) begin
          chr_slot_nxt[{swap_r, s1_item_r.address[0], 1'b0}] = pair;
          chr_slot_nxt[{swap_r, s1_item_r.address[0], 1'b1}] = pair + 8'd1;
        end else if (s1_item_r.address >= ADDR_CHR_SINGLE_0 &&
                     s1_item_r.address <= ADDR_CHR_SINGLE_3) begin
          chr_slot_nxt[{!swap_r, low_off}] = s1_item_r.data;
        end else if (s1_item_r.address == ADDR_CONTROL) begin
          swap_nxt   = s1_item_r.data[SWAP_BIT];
          mirror_nxt = s1_item_r.data[MIRROR_BIT];
        end else if (s1_item_r.address >= ADDR_PRG_0 &&
                     s1_item_r.address <= ADDR_PRG_2) begin
          prg_slot_nxt[low_off] = {2'b00, s1_item_r.data[7:2]};
        end
      end
      OP_PRG_XLATE: begin
        if (s1_item_r.address[15]) begin
          out_item_nxt.bank = prg_slot_r[s1_item_r.address[14:13]];
        end
      end
      OP_CHR_XLATE: begin
        out_item_nxt.bank = chr_slot_r[s1_item_r.address[12:10]];
      end
      default: ;
    endcase
    out_item_nxt.mirroring_vertical = mirror_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r <= PRG_COUNT_RST;
      chr_count_r <= CHR_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PRG_COUNT) begin
        prg_count_r <= cfg_data;
      end else if (cfg_index == CFG_CHR_COUNT) begin
        chr_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prg_slot_r  <= '{8'd0, 8'd1, PRG_COUNT_RST[7:0] - 8'd2, PRG_COUNT_RST[7:0] - 8'd1};
      for (int i = 0; i < 8; i++) begin
        chr_slot_r[i] <= 8'(i);
      end
      swap_r   <= 1'b0;
      mirror_r <= 1'b1;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        prg_slot_r <= prg_slot_nxt;
        chr_slot_r <= chr_slot_nxt;
        swap_r     <= swap_nxt;
        mirror_r   <= mirror_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  // stalled input stage keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost or changed a stalled request");

  a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed request produced no result");

  a_mirror_match: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_item_r.mirroring_vertical == mirror_r))
    else $error("result mirroring differs from mirroring state");

  a_low_prg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_item_r.operation == OP_PRG_XLATE && !s1_item_r.address[15])
    |=> (out_item_r.bank == 8'd0))
    else $error("program translate below 0x8000 gave nonzero bank");

  a_reset_load: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_item_r.operation == OP_RESET_LOAD)
    |=> (prg_slot_r[0] == 8'd0 && prg_slot_r[1] == 8'd1 && !swap_r && mirror_r))
    else $error("reset-load did not restore fixed slots");

endmodule

// ----- tb/sv/cbm_mapper_checker.sv -----
module cbm_mapper_checker
  import cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         pending,
  output int         fail_count
);

  logic [8:0] prg_count;
  logic [8:0] chr_count;
  logic [7:0] prg_slot [4];
  logic [7:0] chr_slot [8];
  logic       swap_mode;
  logic       mirror_v;

  out_item_t  bank_mirror_q [$];
  int         mismatches = 0;

  assign fail_count = mismatches;

  function automatic void reload_slots();
    logic [8:0] top2;
    logic [8:0] top1;
    top2 = prg_count - 9'd2;
    top1 = prg_count - 9'd1;
    prg_slot[0] = 8'd0;
    prg_slot[1] = 8'd1;
    prg_slot[2] = top2[7:0];
    prg_slot[3] = top1[7:0];
    // pattern RAM (count 0): slots keep whatever was loaded before
    if (chr_count != 9'd0) begin
      for (int i = 0; i < 8; i++) chr_slot[i] = 8'(i);
    end
    swap_mode = 1'b0;
    mirror_v  = 1'b1;
  endfunction

  function automatic out_item_t mapper_step(input in_item_t req);
    out_item_t  res;
    logic [2:0] base;
    logic [2:0] s;
    logic [7:0] pair;
    logic [15:0] a;
    a = req.address;
    res.bank = 8'd0;
    case (op_t'(req.operation))
      OP_RESET_LOAD: reload_slots();
      OP_REG_WRITE: begin
        base = swap_mode ? 3'd4 : 3'd0;
        if (a == ADDR_CHR_PAIR_LO || a == ADDR_CHR_PAIR_HI) begin
          s    = base + 3'(2 * (a - ADDR_CHR_PAIR_LO));
          pair = req.data & PAIR_MASK;
          chr_slot[s]        = pair;
          chr_slot[s + 3'd1] = pair + 8'd1;
        end else if (a >= ADDR_CHR_SINGLE_0 && a <= ADDR_CHR_SINGLE_3) begin
          s = (3'd4 - base) + 3'(a - ADDR_CHR_SINGLE_0);
          chr_slot[s] = req.data;
        end else if (a == ADDR_CONTROL) begin
          swap_mode = req.data[SWAP_BIT];
          mirror_v  = req.data[MIRROR_BIT];
        end else if (a >= ADDR_PRG_0 && a <= ADDR_PRG_2) begin
          prg_slot[2'(a - ADDR_PRG_0)] = req.data >> 2;
        end
      end
      OP_PRG_XLATE: begin
        if (a[15]) res.bank = prg_slot[a[14:13]];
      end
      default: res.bank = chr_slot[a[12:10]];
    endcase
    res.mirroring_vertical = mirror_v;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      prg_count = PRG_COUNT_RST;
      chr_count = CHR_COUNT_RST;
      reload_slots();
      bank_mirror_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRG_COUNT: prg_count = cfg_data;
          CFG_CHR_COUNT: chr_count = cfg_data;
          default: ;
        endcase
      end
      // check the older result before queuing this edge's request
      if (out_valid && out_ready) begin
        if (bank_mirror_q.size() == 0) begin
          $error("unexpected result: bank %0d, mirroring_vertical %0d",
                 out_item.bank, out_item.mirroring_vertical);
          mismatches++;
        end else begin
          want = bank_mirror_q.pop_front();
          if (out_item.bank !== want.bank) begin
            $error("bank: expected %0d, actual %0d", want.bank, out_item.bank);
            mismatches++;
          end
          if (out_item.mirroring_vertical !== want.mirroring_vertical) begin
            $error("mirroring_vertical: expected %0d, actual %0d",
                   want.mirroring_vertical, out_item.mirroring_vertical);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) bank_mirror_q.push_back(mapper_step(in_item));
    end
    pending <= bank_mirror_q.size();
  end

endmodule

// ----- tb/sv/cartridge_bank_mapper_x1_017_core_tb.sv -----
module cartridge_bank_mapper_x1_017_core_tb;
  import cbm_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  int         pending;
  int         fail_count;

  bit no_gap   = 1'b0;
  bit no_stall = 1'b0;

  cartridge_bank_mapper_x1_017_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cbm_mapper_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic in_item_t mk(input op_t op, input logic [15:0] a, input logic [7:0] d);
    in_item_t r;
    r.operation = op;
    r.address   = a;
    r.data      = d;
    return r;
  endfunction

  task automatic send_req(input in_item_t req);
    int gap;
    gap = no_gap ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_counts(input logic [8:0] prg, input logic [8:0] chr);
    bit flip;
    flip = $urandom_range(0, 1);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      if ((i == 0) ^ flip) begin
        cfg_index <= CFG_PRG_COUNT;
        cfg_data  <= prg;
      end else begin
        cfg_index <= CFG_CHR_COUNT;
        cfg_data  <= chr;
      end
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    forever begin
      int stall;
      stall = no_stall ? 0 : idle_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    in_item_t directed [$];
    in_item_t r;
    int       pick;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    directed.push_back(mk(OP_PRG_XLATE, 16'h8000, 8'h00));
    directed.push_back(mk(OP_PRG_XLATE, 16'hA000, 8'hFF));
    directed.push_back(mk(OP_PRG_XLATE, 16'hC000, 8'h00));
    directed.push_back(mk(OP_PRG_XLATE, 16'hFFFF, 8'h00));
    directed.push_back(mk(OP_PRG_XLATE, 16'h7FFF, 8'h00));  // below program space
    directed.push_back(mk(OP_CHR_XLATE, 16'h0000, 8'h00));
    directed.push_back(mk(OP_CHR_XLATE, 16'h1FFF, 8'h00));
    directed.push_back(mk(OP_CHR_XLATE, 16'hFC00, 8'h00));  // above pattern space
    directed.push_back(mk(OP_REG_WRITE, ADDR_CHR_PAIR_LO, 8'hFF));
    directed.push_back(mk(OP_REG_WRITE, ADDR_CHR_PAIR_HI, 8'h00));
    directed.push_back(mk(OP_REG_WRITE, ADDR_CHR_SINGLE_0, 8'hAA));
    directed.push_back(mk(OP_REG_WRITE, ADDR_CHR_SINGLE_3, 8'h55));
    directed.push_back(mk(OP_REG_WRITE, ADDR_CONTROL, 8'h03));
    directed.push_back(mk(OP_REG_WRITE, ADDR_CHR_PAIR_LO, 8'h11));
    directed.push_back(mk(OP_REG_WRITE, 16'h7EF3, 8'h80));
    directed.push_back(mk(OP_CHR_XLATE, 16'h1000, 8'h00));
    directed.push_back(mk(OP_CHR_XLATE, 16'h0400, 8'h00));
    directed.push_back(mk(OP_REG_WRITE, ADDR_CONTROL, 8'h02));
    directed.push_back(mk(OP_REG_WRITE, ADDR_PRG_0, 8'hFF));
    directed.push_back(mk(OP_REG_WRITE, 16'h7EFB, 8'h00));
    directed.push_back(mk(OP_REG_WRITE, ADDR_PRG_2, 8'h7F));
    directed.push_back(mk(OP_REG_WRITE, 16'h7EF7, 8'h33));  // ignored addresses
    directed.push_back(mk(OP_REG_WRITE, 16'h7EFD, 8'h44));
    directed.push_back(mk(OP_REG_WRITE, 16'hFFFF, 8'h12));
    directed.push_back(mk(OP_PRG_XLATE, 16'hE000, 8'h00));
    directed.push_back(mk(OP_CHR_XLATE, 16'h0C00, 8'h00));
    directed.push_back(mk(OP_RESET_LOAD, 16'hFFFF, 8'hFF));
    directed.push_back(mk(OP_PRG_XLATE, 16'hC000, 8'h00));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      no_gap   = (ph == 2) || (ph == 5);
      no_stall = (ph == 2) || (ph == 4);
      if (ph == 0) begin
        for (int i = 0; i < directed.size(); i++) send_req(directed[i]);
      end else begin
        wait_idle();
        case (ph)
          1: set_counts(9'd2, 9'd0);
          2: set_counts(9'd256, 9'd256);
          3: set_counts(9'd0, 9'd1);
          4: set_counts(9'($urandom_range(2, 256)), 9'($urandom_range(0, 256)));
          default: set_counts(9'd255, 9'd255);
        endcase
        // new counts only reach the slots through a reset-load
        send_req(mk(OP_RESET_LOAD, 16'($urandom), 8'($urandom)));
      end
      repeat (84) begin
        r.address = 16'($urandom);
        r.data    = 8'($urandom);
        pick      = $urandom_range(0, 99);
        if (pick < 4) begin
          r.operation = OP_RESET_LOAD;
        end else if (pick < 40) begin
          r.operation = OP_REG_WRITE;
          if ($urandom_range(0, 4) != 0)
            r.address = ADDR_CHR_PAIR_LO + 16'($urandom_range(0, 15));
        end else if (pick < 70) begin
          r.operation = OP_PRG_XLATE;
        end else begin
          r.operation = OP_CHR_XLATE;
          if ($urandom_range(0, 3) != 0) r.address[15:13] = 3'd0;
        end
        send_req(r);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cbm_pkg.sv
hw/rtl/cartridge_bank_mapper_x1_017_core.sv
tb/sv/cbm_mapper_checker.sv
tb/sv/cartridge_bank_mapper_x1_017_core_tb.sv
